### rtl/core/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg: shared types and constants for the mass-spring particle engine
// Operation codes, register indexes, iterative unit control, saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

   // operation codes carried in req_tuser
   typedef enum logic [3:0] {
      OP_LOAD_POS  = 4'd0,
      OP_LOAD_MOM  = 4'd1,
      OP_LOAD_MASS = 4'd2,
      OP_CLEAR     = 4'd3,
      OP_SPRING    = 4'd4,
      OP_DRAG      = 4'd5,
      OP_UPD_MOM   = 4'd6,
      OP_UPD_POS   = 4'd7,
      OP_READ      = 4'd8
   } op_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      REG_TIME_STEP = 2'd0,
      REG_VISCOSITY = 2'd1,
      REG_COUNT     = 2'd2
   } reg_type;

   typedef enum logic {
      UNIT_DIV  = 1'b0,
      UNIT_SQRT = 1'b1
   } unit_mode_type;

   typedef struct packed {
      logic          start;
      unit_mode_type mode;
   } unit_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic rem_nz;
   } unit_sts_type;

   localparam logic [6:0] DIV_STEPS  = 7'd64;
   localparam logic [6:0] SQRT_STEPS = 7'd32;

   function automatic logic signed [63:0] sx32(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/msp_divsqrt.sv
// ----------------------------------------------------------------------------
// msp_divsqrt: shared iterative divide / square-root unit
// Restoring 64/32 divide (one quotient bit per cycle) or 64-bit integer
// square root (one root bit per cycle).
// ----------------------------------------------------------------------------
`default_nettype none

module msp_divsqrt
   import msp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire unit_ctl_type ctl,
   input  wire logic [63:0]  operand,   // dividend or radicand
   input  wire logic [31:0]  divisor,
   output      unit_sts_type sts,
   output      logic [63:0]  result     // quotient, or root in low bits
);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   unit_mode_type mode_ff, mode_in;
   logic [6:0]    cnt_ff, cnt_in;
   logic [63:0]   x_ff, x_in;
   logic [33:0]   rem_ff, rem_in;
   logic [31:0]   root_ff, root_in;
   logic [31:0]   dvs_ff, dvs_in;

   logic [32:0]   div_t;
   logic [33:0]   div_diff;
   logic [33:0]   sq_t;
   logic [33:0]   sq_trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      mode_in  = mode_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      dvs_in   = dvs_ff;
      div_t    = {rem_ff[31:0], x_ff[63]};
      div_diff = {1'b0, div_t} - {2'b00, dvs_ff};
      sq_t     = {rem_ff[31:0], x_ff[63:62]};
      sq_trial = {root_ff, 2'b01};

      if (ctl.start) begin
         busy_in = 1'b1;
         mode_in = ctl.mode;
         cnt_in  = (ctl.mode == UNIT_DIV) ? DIV_STEPS : SQRT_STEPS;
         x_in    = operand;
         rem_in  = '0;
         root_in = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (mode_ff == UNIT_DIV) begin
            if (!div_diff[33]) begin
               rem_in = {1'b0, div_diff[32:0]};
               x_in   = {x_ff[62:0], 1'b1};
            end else begin
               rem_in = {1'b0, div_t};
               x_in   = {x_ff[62:0], 1'b0};
            end
         end else begin
            if (sq_t >= sq_trial) begin
               rem_in  = sq_t - sq_trial;
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in  = sq_t;
               root_in = {root_ff[30:0], 1'b0};
            end
            x_in = {x_ff[61:0], 2'b00};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mode_ff <= mode_in;
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      dvs_ff  <= dvs_in;
   end

   assign sts.busy   = busy_ff;
   assign sts.done   = done_ff;
   assign sts.rem_nz = (rem_ff != '0);
   assign result     = (mode_ff == UNIT_DIV) ? x_ff : {32'd0, root_ff};

endmodule

`default_nettype wire

### rtl/core/mass_spring_particle_step.sv
// ----------------------------------------------------------------------------
// mass_spring_particle_step: fixed-point mass-spring particle engine
// Particle table (position, momentum, force, mass) with load, spring, drag,
// symplectic Euler integration and read transactions.
// ----------------------------------------------------------------------------
// Sequencing: a spring runs a square root and then a divide on the shared unit;
//   position update runs a divide per component of each particle with nonzero
//   mass; clear, drag and momentum update walk the table word by word.
// Flow: one transaction at a time; the shared divide/root unit and the
//   simple dual-port memories set the pace. req_tready is high only when idle.
// Reset: synchronous, active high. Afterwards the force memory is zeroed by a
//   sweep over all 3*MAX_PARTICLES words with req_tready low.
`default_nettype none

module mass_spring_particle_step
   import msp_pkg::*;
#(
   parameter int MAX_PARTICLES = 256,
   parameter int FRAC_BITS     = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request transactions
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   // tdata: particle_a[7:0], particle_b[15:8], vec_x[47:16], vec_y[79:48],
   //        vec_z[111:80], particle_mass[142:112], rest_length[173:143],
   //        stiffness[204:174], zero fill [207:205]
   input  wire logic [207:0] req_tdata,
   // tuser: operation[3:0]
   input  wire logic [3:0]   req_tuser,
   // response transactions (read only)
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata: particle_index[7:0], pos_x[39:8], pos_y[71:40], pos_z[103:72],
   //        mom_x[135:104], mom_y[167:136], mom_z[199:168], force_x[231:200],
   //        force_y[263:232], force_z[295:264]
   output      logic [295:0] rsp_tdata,
   // register writes
   input  wire logic         csr_valid,
   output      logic         csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data
);

   localparam int WORDS = 3 * MAX_PARTICLES;
   localparam int AW    = $clog2(WORDS);
   localparam int IW    = $clog2(MAX_PARTICLES);
   localparam int NW    = $clog2(MAX_PARTICLES + 1);
   localparam int WCW   = $clog2(WORDS + 1);

   typedef enum logic [5:0] {
      S_CLEAR, S_IDLE, S_LOAD, S_FCLR,
      S_W_RD, S_W_MUL, S_W_WR,
      S_P_MRD, S_P_MCHK, S_P_RD, S_P_MUL, S_P_DIV, S_P_DWAIT, S_P_WR,
      S_S_RDB, S_S_RDA, S_S_DIF, S_S_SQ, S_S_ACC, S_S_SQRT, S_S_SWAIT,
      S_S_DIV, S_S_DWAIT, S_S_KMUL, S_S_COEF, S_S_FMUL, S_S_FRA, S_S_FWA,
      S_S_FRB, S_S_FWB,
      S_RD_A, S_RD_B, S_RSP
   } state_type;

   // ---- particle memories: one write, one registered read each
   logic [31:0] pos_mem  [WORDS];
   logic [31:0] mom_mem  [WORDS];
   logic [31:0] frc_mem  [WORDS];
   logic [30:0] mass_mem [MAX_PARTICLES];

   logic          pos_we, pos_re, mom_we, mom_re, frc_we, frc_re, mass_we, mass_re;
   logic [AW-1:0] pos_wa, pos_ra, mom_wa, mom_ra, frc_wa, frc_ra;
   logic [IW-1:0] mass_wa, mass_ra;
   logic [31:0]   pos_wd, mom_wd, frc_wd;
   logic [30:0]   mass_wd;
   logic [31:0]   pos_rd_ff, mom_rd_ff, frc_rd_ff;
   logic [30:0]   mass_rd_ff;

   always_ff @(posedge clock) begin
      if (pos_we) pos_mem[pos_wa] <= pos_wd;
      if (pos_re) pos_rd_ff <= pos_mem[pos_ra];
   end

   always_ff @(posedge clock) begin
      if (mom_we) mom_mem[mom_wa] <= mom_wd;
      if (mom_re) mom_rd_ff <= mom_mem[mom_ra];
   end

   always_ff @(posedge clock) begin
      if (frc_we) frc_mem[frc_wa] <= frc_wd;
      if (frc_re) frc_rd_ff <= frc_mem[frc_ra];
   end

   always_ff @(posedge clock) begin
      if (mass_we) mass_mem[mass_wa] <= mass_wd;
      if (mass_re) mass_rd_ff <= mass_mem[mass_ra];
   end

   // ---- shared divide / square-root unit
   unit_ctl_type unit_ctl;
   unit_sts_type unit_sts;
   logic [63:0]  unit_opd;
   logic [31:0]  unit_dvs;
   logic [63:0]  unit_res;

   msp_divsqrt u_divsqrt (
      .clock   (clock),
      .reset   (reset),
      .ctl     (unit_ctl),
      .operand (unit_opd),
      .divisor (unit_dvs),
      .sts     (unit_sts),
      .result  (unit_res)
   );

   // ---- shared multiplier, registered
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_full;
   assign mul_full = mul_a * mul_b;

   // ---- registers
   state_type       state_ff, state_in;
   logic [3:0]      op_ff, op_in;
   logic [7:0]      a_ff, a_in;
   logic [AW-1:0]   base_a_ff, base_a_in, base_b_ff, base_b_in;
   logic [31:0]     vec_ff [3];
   logic [31:0]     vec_in [3];
   logic [30:0]     mass_ff, mass_in, rest_ff, rest_in, k_ff, k_in;
   logic [1:0]      i_ff, i_in;
   logic [WCW-1:0]  w_ff, w_in, end_ff, end_in;
   logic [NW-1:0]   p_ff, p_in, n_ff, n_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [63:0]     sum_ff, sum_in;
   logic [31:0]     d_ff [3];
   logic [31:0]     d_in [3];
   logic [31:0]     hold_ff, hold_in, coef_ff, coef_in, f_ff, f_in;
   logic            neg_ff, neg_in;
   logic [31:0]     stg_pos_ff [3];
   logic [31:0]     stg_pos_in [3];
   logic [31:0]     stg_mom_ff [3];
   logic [31:0]     stg_mom_in [3];
   logic [31:0]     stg_frc_ff [3];
   logic [31:0]     stg_frc_in [3];
   logic            rsp_valid_ff, rsp_valid_in;
   logic [295:0]    rsp_data_ff, rsp_data_in;
   logic [30:0]     ts_ff, ts_in, visc_ff, visc_in;
   logic [8:0]      cnt_ff, cnt_in;

   // ---- request decode
   logic [3:0]      req_op;
   logic [7:0]      req_a, req_b;
   logic            a_ok, b_ok;
   logic [NW-1:0]   walk_n;
   logic [WCW-1:0]  walk_end;
   logic [AW-1:0]   addr_a, addr_b;
   logic signed [63:0] delta, quo_s;

   assign req_op = req_tuser;
   assign req_a  = req_tdata[7:0];
   assign req_b  = req_tdata[15:8];
   assign a_ok   = ({24'd0, req_a} < 32'(MAX_PARTICLES));
   assign b_ok   = ({24'd0, req_b} < 32'(MAX_PARTICLES));
   assign walk_n = ({23'd0, cnt_ff} < 32'(MAX_PARTICLES)) ? NW'(cnt_ff)
                                                         : NW'(MAX_PARTICLES);
   assign walk_end = (WCW'(walk_n) << 1) + WCW'(walk_n);
   assign addr_a   = base_a_ff + AW'(i_ff);
   assign addr_b   = base_b_ff + AW'(i_ff);
   assign delta    = prod_ff >>> FRAC_BITS;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      a_in         = a_ff;
      base_a_in    = base_a_ff;
      base_b_in    = base_b_ff;
      vec_in       = vec_ff;
      mass_in      = mass_ff;
      rest_in      = rest_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      w_in         = w_ff;
      end_in       = end_ff;
      p_in         = p_ff;
      n_in         = n_ff;
      prod_in      = mul_full[63:0];
      sum_in       = sum_ff;
      d_in         = d_ff;
      hold_in      = hold_ff;
      coef_in      = coef_ff;
      f_in         = f_ff;
      neg_in       = neg_ff;
      stg_pos_in   = stg_pos_ff;
      stg_mom_in   = stg_mom_ff;
      stg_frc_in   = stg_frc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ts_in        = ts_ff;
      visc_in      = visc_ff;
      cnt_in       = cnt_ff;
      mul_a        = '0;
      mul_b        = '0;
      unit_ctl.start = 1'b0;
      unit_ctl.mode  = UNIT_DIV;
      unit_opd     = '0;
      unit_dvs     = '0;
      quo_s        = '0;
      pos_we = 1'b0; pos_re = 1'b0; pos_wa = '0; pos_ra = '0; pos_wd = '0;
      mom_we = 1'b0; mom_re = 1'b0; mom_wa = '0; mom_ra = '0; mom_wd = '0;
      frc_we = 1'b0; frc_re = 1'b0; frc_wa = '0; frc_ra = '0; frc_wd = '0;
      mass_we = 1'b0; mass_re = 1'b0; mass_wa = '0; mass_ra = '0; mass_wd = '0;

      // result register drains independently of the sequencer
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // register writes
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_TIME_STEP: ts_in   = csr_data[30:0];
            REG_VISCOSITY: visc_in = csr_data[30:0];
            REG_COUNT:     cnt_in  = csr_data[8:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         // zero the force memory after reset
         S_CLEAR: begin
            frc_we = 1'b1;
            frc_wa = w_ff[AW-1:0];
            frc_wd = '0;
            w_in   = w_ff + WCW'(1);
            if (w_ff == WCW'(WORDS - 1)) begin
               w_in     = '0;
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_op;
               a_in      = req_a;
               base_a_in = AW'(({2'b00, req_a} << 1) + {2'b00, req_a});
               base_b_in = AW'(({2'b00, req_b} << 1) + {2'b00, req_b});
               vec_in[0] = req_tdata[47:16];
               vec_in[1] = req_tdata[79:48];
               vec_in[2] = req_tdata[111:80];
               mass_in   = req_tdata[142:112];
               rest_in   = req_tdata[173:143];
               k_in      = req_tdata[204:174];
               i_in      = '0;
               w_in      = '0;
               p_in      = '0;
               n_in      = walk_n;
               end_in    = walk_end;
               sum_in    = '0;
               unique case (req_op)
                  OP_LOAD_POS, OP_LOAD_MOM, OP_LOAD_MASS:
                     state_in = a_ok ? S_LOAD : S_IDLE;
                  OP_CLEAR:
                     state_in = (walk_end == '0) ? S_IDLE : S_FCLR;
                  OP_SPRING:
                     state_in = (a_ok && b_ok) ? S_S_RDB : S_IDLE;
                  OP_DRAG, OP_UPD_MOM:
                     state_in = (walk_end == '0) ? S_IDLE : S_W_RD;
                  OP_UPD_POS:
                     state_in = (walk_n == '0) ? S_IDLE : S_P_MRD;
                  OP_READ:
                     state_in = a_ok ? S_RD_A : S_IDLE;
                  default:
                     state_in = S_IDLE;
               endcase
            end
         end

         S_LOAD: begin
            pos_wa  = addr_a;
            mom_wa  = addr_a;
            pos_wd  = vec_ff[i_ff];
            mom_wd  = vec_ff[i_ff];
            mass_wa = IW'(a_ff);
            mass_wd = mass_ff;
            i_in    = i_ff + 2'd1;
            unique case (op_ff)
               OP_LOAD_POS:  pos_we  = 1'b1;
               OP_LOAD_MOM:  mom_we  = 1'b1;
               OP_LOAD_MASS: mass_we = 1'b1;
               default: ;
            endcase
            if (op_ff == OP_LOAD_MASS || i_ff == 2'd2) begin
               state_in = S_IDLE;
            end
         end

         S_FCLR: begin
            frc_we = 1'b1;
            frc_wa = w_ff[AW-1:0];
            frc_wd = '0;
            w_in   = w_ff + WCW'(1);
            if (w_ff + WCW'(1) == end_ff) state_in = S_IDLE;
         end

         // drag and momentum update: each word is read, multiplied and written back
         S_W_RD: begin
            mom_re   = 1'b1;
            mom_ra   = w_ff[AW-1:0];
            frc_re   = 1'b1;
            frc_ra   = w_ff[AW-1:0];
            state_in = S_W_MUL;
         end

         S_W_MUL: begin
            if (op_ff == OP_DRAG) begin
               mul_a = {2'b00, visc_ff};
               mul_b = 33'sd0 - {mom_rd_ff[31], mom_rd_ff};
            end else begin
               mul_a = {2'b00, ts_ff};
               mul_b = {frc_rd_ff[31], frc_rd_ff};
            end
            state_in = S_W_WR;
         end

         S_W_WR: begin
            if (op_ff == OP_DRAG) begin
               frc_we = 1'b1;
               frc_wa = w_ff[AW-1:0];
               frc_wd = sat32(sx32(frc_rd_ff) + delta);
            end else begin
               mom_we = 1'b1;
               mom_wa = w_ff[AW-1:0];
               mom_wd = sat32(sx32(mom_rd_ff) + delta);
            end
            w_in     = w_ff + WCW'(1);
            state_in = (w_ff + WCW'(1) == end_ff) ? S_IDLE : S_W_RD;
         end

         // position update: x += floor(dt*p/m) per component
         S_P_MRD: begin
            mass_re  = 1'b1;
            mass_ra  = p_ff[IW-1:0];
            state_in = S_P_MCHK;
         end

         S_P_MCHK: begin
            i_in = '0;
            if (mass_rd_ff == '0) begin
               // massless particle keeps its position
               p_in     = p_ff + NW'(1);
               w_in     = w_ff + WCW'(3);
               state_in = (p_ff + NW'(1) == n_ff) ? S_IDLE : S_P_MRD;
            end else begin
               state_in = S_P_RD;
            end
         end

         S_P_RD: begin
            mom_re   = 1'b1;
            mom_ra   = w_ff[AW-1:0];
            pos_re   = 1'b1;
            pos_ra   = w_ff[AW-1:0];
            state_in = S_P_MUL;
         end

         S_P_MUL: begin
            mul_a    = {2'b00, ts_ff};
            mul_b    = {mom_rd_ff[31], mom_rd_ff};
            state_in = S_P_DIV;
         end

         S_P_DIV: begin
            neg_in         = prod_ff[63];
            unit_ctl.start = 1'b1;
            unit_ctl.mode  = UNIT_DIV;
            unit_opd       = prod_ff[63] ? 64'(64'sd0 - prod_ff) : prod_ff;
            unit_dvs       = {1'b0, mass_rd_ff};
            state_in       = S_P_DWAIT;
         end

         S_P_DWAIT: begin
            if (unit_sts.done) state_in = S_P_WR;
         end

         S_P_WR: begin
            // negative quotient rounds toward minus infinity
            quo_s  = neg_ff ? 64'(64'd0 - (unit_res + 64'(unit_sts.rem_nz)))
                            : unit_res;
            pos_we = 1'b1;
            pos_wa = w_ff[AW-1:0];
            pos_wd = sat32(sx32(pos_rd_ff) + quo_s);
            w_in   = w_ff + WCW'(1);
            i_in   = i_ff + 2'd1;
            if (i_ff == 2'd2) begin
               i_in     = '0;
               p_in     = p_ff + NW'(1);
               state_in = (p_ff + NW'(1) == n_ff) ? S_IDLE : S_P_MRD;
            end else begin
               state_in = S_P_RD;
            end
         end

         // spring: separation vector and squared length
         S_S_RDB: begin
            pos_re   = 1'b1;
            pos_ra   = addr_b;
            state_in = S_S_RDA;
         end

         S_S_RDA: begin
            hold_in  = pos_rd_ff;
            pos_re   = 1'b1;
            pos_ra   = addr_a;
            state_in = S_S_DIF;
         end

         S_S_DIF: begin
            d_in[i_ff] = sat32(sx32(hold_ff) - sx32(pos_rd_ff));
            state_in   = S_S_SQ;
         end

         S_S_SQ: begin
            mul_a    = {d_ff[i_ff][31], d_ff[i_ff]};
            mul_b    = {d_ff[i_ff][31], d_ff[i_ff]};
            state_in = S_S_ACC;
         end

         S_S_ACC: begin
            sum_in = sum_ff + prod_ff;
            i_in   = i_ff + 2'd1;
            if (i_ff == 2'd2) begin
               i_in     = '0;
               state_in = S_S_SQRT;
            end else begin
               state_in = S_S_RDB;
            end
         end

         S_S_SQRT: begin
            unit_ctl.start = 1'b1;
            unit_ctl.mode  = UNIT_SQRT;
            unit_opd       = sum_ff;
            state_in       = S_S_SWAIT;
         end

         S_S_SWAIT: begin
            // zero length gives no force
            if (unit_sts.done) begin
               state_in = (unit_res[31:0] == '0) ? S_IDLE : S_S_DIV;
            end
         end

         S_S_DIV: begin
            unit_ctl.start = 1'b1;
            unit_ctl.mode  = UNIT_DIV;
            unit_opd       = {33'd0, rest_ff} << FRAC_BITS;
            unit_dvs       = unit_res[31:0];
            state_in       = S_S_DWAIT;
         end

         S_S_DWAIT: begin
            if (unit_sts.done) begin
               coef_in  = sat32(signed'((64'd1 << FRAC_BITS) - unit_res));
               state_in = S_S_KMUL;
            end
         end

         S_S_KMUL: begin
            mul_a    = {2'b00, k_ff};
            mul_b    = {coef_ff[31], coef_ff};
            state_in = S_S_COEF;
         end

         S_S_COEF: begin
            coef_in  = sat32(delta);
            state_in = S_S_FMUL;
         end

         S_S_FMUL: begin
            mul_a    = {coef_ff[31], coef_ff};
            mul_b    = {d_ff[i_ff][31], d_ff[i_ff]};
            state_in = S_S_FRA;
         end

         S_S_FRA: begin
            f_in     = sat32(delta);
            frc_re   = 1'b1;
            frc_ra   = addr_a;
            state_in = S_S_FWA;
         end

         S_S_FWA: begin
            frc_we   = 1'b1;
            frc_wa   = addr_a;
            frc_wd   = sat32(sx32(frc_rd_ff) + sx32(f_ff));
            state_in = S_S_FRB;
         end

         // read of b follows the write of a, so a == b nets out correctly
         S_S_FRB: begin
            frc_re   = 1'b1;
            frc_ra   = addr_b;
            state_in = S_S_FWB;
         end

         S_S_FWB: begin
            frc_we = 1'b1;
            frc_wa = addr_b;
            frc_wd = sat32(sx32(frc_rd_ff) - sx32(f_ff));
            i_in   = i_ff + 2'd1;
            state_in = (i_ff == 2'd2) ? S_IDLE : S_S_FMUL;
         end

         // particle read
         S_RD_A: begin
            pos_re   = 1'b1;
            pos_ra   = addr_a;
            mom_re   = 1'b1;
            mom_ra   = addr_a;
            frc_re   = 1'b1;
            frc_ra   = addr_a;
            state_in = S_RD_B;
         end

         S_RD_B: begin
            stg_pos_in[i_ff] = pos_rd_ff;
            stg_mom_in[i_ff] = mom_rd_ff;
            stg_frc_in[i_ff] = frc_rd_ff;
            i_in     = i_ff + 2'd1;
            state_in = (i_ff == 2'd2) ? S_RSP : S_RD_A;
         end

         S_RSP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {stg_frc_ff[2], stg_frc_ff[1], stg_frc_ff[0],
                               stg_mom_ff[2], stg_mom_ff[1], stg_mom_ff[0],
                               stg_pos_ff[2], stg_pos_ff[1], stg_pos_ff[0], a_ff};
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         w_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         ts_ff        <= 31'd655;
         visc_ff      <= '0;
         cnt_ff       <= 9'd256;
      end else begin
         state_ff     <= state_in;
         w_ff         <= w_in;
         rsp_valid_ff <= rsp_valid_in;
         ts_ff        <= ts_in;
         visc_ff      <= visc_in;
         cnt_ff       <= cnt_in;
      end
      op_ff      <= op_in;
      a_ff       <= a_in;
      base_a_ff  <= base_a_in;
      base_b_ff  <= base_b_in;
      vec_ff     <= vec_in;
      mass_ff    <= mass_in;
      rest_ff    <= rest_in;
      k_ff       <= k_in;
      i_ff       <= i_in;
      end_ff     <= end_in;
      p_ff       <= p_in;
      n_ff       <= n_in;
      prod_ff    <= prod_in;
      sum_ff     <= sum_in;
      d_ff       <= d_in;
      hold_ff    <= hold_in;
      coef_ff    <= coef_in;
      f_ff       <= f_in;
      neg_ff     <= neg_in;
      stg_pos_ff <= stg_pos_in;
      stg_mom_ff <= stg_mom_in;
      stg_frc_ff <= stg_frc_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ---- checks
   a_unit_start_idle: assert property (@(posedge clock) disable iff (reset)
      unit_ctl.start |-> !unit_sts.busy)
      else $error("shared unit restarted while busy");

   a_unit_done_pulse: assert property (@(posedge clock) disable iff (reset)
      unit_sts.done |=> !unit_sts.done)
      else $error("unit done held longer than one cycle");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RSP))
      else $error("response raised outside the read sequence");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |=> (state_ff == S_CLEAR || state_ff == S_IDLE))
      else $error("force clear sweep left early");

endmodule

`default_nettype wire

### sim/particle_step_checker.sv
// ----------------------------------------------------------------------------
// particle_step_checker: read-back predictor for the particle engine
// Mirrors the particle table from accepted transactions and compares every
// read result with the oldest predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_step_checker
   import msp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [207:0] req_tdata,
   input  wire logic [3:0]   req_tuser,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [295:0] rsp_tdata,
   input  wire logic         csr_valid,
   input  wire logic         csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data,
   output int                error_count,
   output int                pending
);

   localparam int NPART = 256;
   localparam int FRAC  = 16;

   typedef longint unsigned ulong_type;

   // first member lands in the top bits
   typedef struct packed {
      logic [31:0] force_z, force_y, force_x;
      logic [31:0] mom_z, mom_y, mom_x;
      logic [31:0] pos_z, pos_y, pos_x;
      logic [7:0]  index;
   } particle_view_type;

   logic signed [31:0] pos_tbl [0:3*NPART-1];
   logic signed [31:0] mom_tbl [0:3*NPART-1];
   logic signed [31:0] frc_tbl [0:3*NPART-1];
   logic [30:0]        mass_tbl [0:NPART-1];
   logic [30:0]        dt_reg, visc_reg;
   logic [8:0]         count_reg;

   particle_view_type readback_q [$];

   assign pending = readback_q.size();

   function automatic logic signed [31:0] clamp_word(input longint v);
      if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic longint unsigned root_floor(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic int walk_count();
      return (count_reg < NPART) ? int'(count_reg) : NPART;
   endfunction

   task automatic apply_spring(input int a, input int b, input logic [30:0] rest,
                               input logic [30:0] k);
      longint d [3];
      longint unsigned sq, len;
      longint stretch, coef, f;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
         d[i] = clamp_word(longint'(pos_tbl[3*b+i]) - longint'(pos_tbl[3*a+i]));
         sq += ulong_type'(d[i] * d[i]);
      end
      len = root_floor(sq);
      if (len == 0) return;   // coincident ends: no force
      stretch = clamp_word(65536 - longint'((ulong_type'(rest) << FRAC) / len));
      coef = clamp_word((longint'(k) * stretch) >>> FRAC);
      for (int i = 0; i < 3; i++) begin
         f = clamp_word((coef * d[i]) >>> FRAC);
         frc_tbl[3*a+i] = clamp_word(longint'(frc_tbl[3*a+i]) + f);
         frc_tbl[3*b+i] = clamp_word(longint'(frc_tbl[3*b+i]) - f);
      end
   endtask

   task automatic advance_table(input logic [3:0] code, input logic [207:0] d);
      int a, b, n;
      longint v [3];
      longint num, q, m;
      particle_view_type view;
      a = d[7:0];
      b = d[15:8];
      v[0] = longint'($signed(d[47:16]));
      v[1] = longint'($signed(d[79:48]));
      v[2] = longint'($signed(d[111:80]));
      n = walk_count();
      case (code)
         OP_LOAD_POS: for (int i = 0; i < 3; i++) pos_tbl[3*a+i] = v[i][31:0];
         OP_LOAD_MOM: for (int i = 0; i < 3; i++) mom_tbl[3*a+i] = v[i][31:0];
         OP_LOAD_MASS: mass_tbl[a] = d[142:112];
         OP_CLEAR: for (int j = 0; j < 3*n; j++) frc_tbl[j] = 0;
         OP_SPRING: apply_spring(a, b, d[173:143], d[204:174]);
         OP_DRAG: for (int j = 0; j < 3*n; j++) begin
            q = (-(longint'(visc_reg) * mom_tbl[j])) >>> FRAC;
            frc_tbl[j] = clamp_word(longint'(frc_tbl[j]) + q);
         end
         OP_UPD_MOM: for (int j = 0; j < 3*n; j++) begin
            q = (longint'(dt_reg) * frc_tbl[j]) >>> FRAC;
            mom_tbl[j] = clamp_word(longint'(mom_tbl[j]) + q);
         end
         OP_UPD_POS: for (int p = 0; p < n; p++) begin
            m = longint'(mass_tbl[p]);
            if (m != 0) begin
               for (int i = 0; i < 3; i++) begin
                  num = longint'(dt_reg) * mom_tbl[3*p+i];
                  q = (num >= 0) ? num / m : -((-num + m - 1) / m);   // floor
                  pos_tbl[3*p+i] = clamp_word(longint'(pos_tbl[3*p+i]) + q);
               end
            end
         end
         OP_READ: begin
            view.index = a[7:0];
            view.pos_x = pos_tbl[3*a];   view.pos_y = pos_tbl[3*a+1];
            view.pos_z = pos_tbl[3*a+2];
            view.mom_x = mom_tbl[3*a];   view.mom_y = mom_tbl[3*a+1];
            view.mom_z = mom_tbl[3*a+2];
            view.force_x = frc_tbl[3*a]; view.force_y = frc_tbl[3*a+1];
            view.force_z = frc_tbl[3*a+2];
            readback_q.push_back(view);
         end
         default: ;   // unknown codes are dropped
      endcase
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      particle_view_type got, want;
      if (reset) begin
         for (int j = 0; j < 3*NPART; j++) frc_tbl[j] = 0;
         dt_reg = 31'd655;
         visc_reg = 31'd0;
         count_reg = 9'd256;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TIME_STEP: dt_reg = csr_data[30:0];
               REG_VISCOSITY: visc_reg = csr_data[30:0];
               REG_COUNT:     count_reg = csr_data[8:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (readback_q.size() == 0) begin
               $display("%0t unexpected read result, particle %0d", $realtime, got.index);
               error_count++;
            end else begin
               want = readback_q.pop_front();
               if (got.index !== want.index) report("particle_index", got.index, want.index);
               if (got.pos_x !== want.pos_x) report("pos_x", got.pos_x, want.pos_x);
               if (got.pos_y !== want.pos_y) report("pos_y", got.pos_y, want.pos_y);
               if (got.pos_z !== want.pos_z) report("pos_z", got.pos_z, want.pos_z);
               if (got.mom_x !== want.mom_x) report("mom_x", got.mom_x, want.mom_x);
               if (got.mom_y !== want.mom_y) report("mom_y", got.mom_y, want.mom_y);
               if (got.mom_z !== want.mom_z) report("mom_z", got.mom_z, want.mom_z);
               if (got.force_x !== want.force_x) report("force_x", got.force_x, want.force_x);
               if (got.force_y !== want.force_y) report("force_y", got.force_y, want.force_y);
               if (got.force_z !== want.force_z) report("force_z", got.force_z, want.force_z);
            end
         end
         if (req_tvalid && req_tready) advance_table(req_tuser, req_tdata);
      end
   end

   initial error_count = 0;

endmodule

`default_nettype wire

### sim/tb_mass_spring_particle_step.sv
// ----------------------------------------------------------------------------
// tb_mass_spring_particle_step: randomized test of the particle engine
// Loads the whole table, runs directed corner transactions, then random
// phases under several register settings with random stalls on both sides.
// A separate checker predicts every read and counts mismatches.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_mass_spring_particle_step;
   import msp_pkg::*;

   localparam int WATCHDOG = 300000;   // idle cycles

   logic         clock, reset;
   logic         req_tvalid, req_tready;
   logic [207:0] req_tdata;    // a, b, x, y, z, mass, rest, stiffness, fill
   logic [3:0]   req_tuser;    // operation
   logic         rsp_tvalid, rsp_tready;
   logic [295:0] rsp_tdata;    // index, pos xyz, mom xyz, force xyz
   logic         csr_valid, csr_ready;
   logic [1:0]   csr_index;
   logic [31:0]  csr_data;
   int           error_count, pending;

   bit quiet;        // no random gaps on either side while set
   bit hold_rsp;     // receiver holds off for a long stretch when set
   int cur_count;    // particle_count as last written
   int idle_cycles;

   mass_spring_particle_step dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   particle_step_checker chk (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .error_count, .pending
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: any cycle without a transaction on any channel counts
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("tb_mass_spring_particle_step failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: random readiness gaps, plus one long hold-off on request
   initial begin
      int gap;
      rsp_tready = 1'b0;
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            @(negedge clock) rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
         end else begin
            gap = quiet ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
               @(negedge clock) rsp_tready <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
         @(negedge clock) rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // one request transaction; valid stays high across back-to-back items
   task automatic offer(input logic [3:0] code, input int a, input int b,
                        input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                        input logic [30:0] m, input logic [30:0] rest,
                        input logic [30:0] k);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= code;
      req_tdata  <= {3'b000, k, rest, m, z, y, x, b[7:0], a[7:0]};
      do @(posedge clock); while (!req_tready);
   endtask

   // let the block run dry: all reads back, then the longest op's latency
   task automatic drain();
      @(negedge clock) req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (300 + 220 * cur_count) @(posedge clock);
   endtask

   task automatic write_reg(input reg_type idx, input int unsigned value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   task automatic set_regs(input int unsigned dt, input int unsigned visc, input int cnt);
      drain();
      write_reg(REG_TIME_STEP, dt);
      write_reg(REG_VISCOSITY, visc);
      write_reg(REG_COUNT, cnt);
      cur_count = cnt;
   endtask

   // mostly modest values, with the extremes and full-range words mixed in
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom;
         default: return $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
      endcase
   endfunction

   function automatic logic [30:0] pick_unsigned();
      case ($urandom_range(0, 7))
         0: return 31'h7FFF_FFFF;
         1: return 31'($urandom_range(0, 1));
         2: return 31'($urandom);
         default: return 31'($urandom_range(0, 32'h0004_0000));
      endcase
   endfunction

   function automatic int pick_particle();
      if (cur_count < 256 && $urandom_range(0, 9) < 7) return $urandom_range(0, cur_count - 1);
      return $urandom_range(0, 255);
   endfunction

   // random phase; table-wide ops are rationed when the walk is long
   task automatic random_phase(input int items, input int table_ops);
      int done_items, roll;
      logic [30:0] m;
      done_items = 0;
      while (done_items < items) begin
         if ($urandom_range(0, 99) < 10) quiet = ~quiet;   // stretches without idling
         roll = $urandom_range(0, 99);
         m = pick_unsigned();
         if (m == 0) m = 31'd1;
         if (roll < 10) begin
            offer(OP_LOAD_POS, pick_particle(), 0, pick_word(), pick_word(), pick_word(),
                  0, 0, 0);
         end else if (roll < 20) begin
            offer(OP_LOAD_MOM, pick_particle(), 0, pick_word(), pick_word(), pick_word(),
                  0, 0, 0);
         end else if (roll < 28) begin
            offer(OP_LOAD_MASS, pick_particle(), 0, 0, 0, 0, m, 0, 0);
         end else if (roll < 55) begin
            offer(OP_SPRING, pick_particle(), pick_particle(), 0, 0, 0, 0,
                  pick_unsigned(), pick_unsigned());
         end else if (roll < 80) begin
            offer(OP_READ, pick_particle(), 0, 0, 0, 0, 0, 0, 0);
         end else if (roll < 97) begin
            if (table_ops > 0) begin
               table_ops--;
               case ($urandom_range(0, 3))
                  0: offer(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
                  1: offer(OP_DRAG, 0, 0, 0, 0, 0, 0, 0, 0);
                  2: offer(OP_UPD_MOM, 0, 0, 0, 0, 0, 0, 0, 0);
                  default: offer(OP_UPD_POS, 0, 0, 0, 0, 0, 0, 0, 0);
               endcase
            end else begin
               offer(OP_READ, pick_particle(), 0, 0, 0, 0, 0, 0, 0);
            end
         end else begin
            // unknown code with random payload; ignored, not counted
            offer(4'($urandom_range(9, 15)), $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom, $urandom, $urandom, 31'($urandom), 31'($urandom),
                  31'($urandom));
            continue;
         end
         done_items++;
      end
   endtask

   initial begin
      idle_cycles = 0;
      quiet = 1'b0;
      hold_rsp = 1'b0;
      cur_count = 256;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // every entry is loaded before anything reads it
      quiet = 1'b1;
      for (int p = 0; p < 256; p++) begin
         offer(OP_LOAD_POS, p, 0, pick_word(), pick_word(), pick_word(), 0, 0, 0);
         offer(OP_LOAD_MOM, p, 0, pick_word(), pick_word(), pick_word(), 0, 0, 0);
         offer(OP_LOAD_MASS, p, 0, 0, 0, 0, 31'($urandom_range(1, 32'h0008_0000)), 0, 0);
      end
      quiet = 1'b0;

      // directed corners at the largest settings
      set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 256);
      offer(OP_LOAD_POS, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
      offer(OP_LOAD_POS, 255, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
      offer(OP_LOAD_MOM, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
      offer(OP_LOAD_MOM, 255, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
      offer(OP_LOAD_MASS, 0, 0, 0, 0, 0, 31'h7FFF_FFFF, 0, 0);
      offer(OP_LOAD_MASS, 255, 0, 0, 0, 0, 31'd1, 0, 0);
      offer(OP_SPRING, 0, 255, 0, 0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      offer(OP_SPRING, 255, 0, 0, 0, 0, 0, 31'd0, 31'h7FFF_FFFF);
      offer(OP_SPRING, 7, 7, 0, 0, 0, 0, 31'h0001_0000, 31'h0001_0000);  // zero length
      offer(OP_SPRING, 1, 2, 0, 0, 0, 0, 31'd0, 31'd0);
      offer(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
      offer(OP_READ, 255, 0, 0, 0, 0, 0, 0, 0);
      offer(OP_DRAG, 0, 0, 0, 0, 0, 0, 0, 0);
      offer(OP_UPD_MOM, 0, 0, 0, 0, 0, 0, 0, 0);
      offer(OP_UPD_POS, 0, 0, 0, 0, 0, 0, 0, 0);
      offer(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
      offer(OP_READ, 255, 0, 0, 0, 0, 0, 0, 0);
      offer(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
      offer(OP_READ, 1, 0, 0, 0, 0, 0, 0, 0);
      offer(4'd15, 3, 4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      offer(4'd9, 0, 0, 0, 0, 0, 0, 0, 0);

      // back-pressure: receiver stalls while reads keep coming
      quiet = 1'b1;
      hold_rsp = 1'b1;
      for (int j = 0; j < 5; j++) offer(OP_READ, j, 0, 0, 0, 0, 0, 0, 0);
      quiet = 1'b0;

      set_regs(1, 0, 1);
      random_phase(120, 60);
      set_regs(655, 32'h0000_8000, 8);
      random_phase(120, 60);
      set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16);
      random_phase(120, 60);
      set_regs($urandom & 32'h7FFF_FFFF, $urandom_range(0, 32'h0002_0000),
               $urandom_range(1, 16));
      random_phase(120, 60);
      set_regs(0, 1, 2);
      random_phase(120, 60);
      set_regs(32'h0001_0000, 32'h0000_1999, 256);
      random_phase(120, 4);

      drain();
      if (error_count == 0 && pending == 0) begin
         $display("tb_mass_spring_particle_step passed");
      end else begin
         $display("tb_mass_spring_particle_step failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

### mass_spring_particle_step.f
rtl/core/msp_pkg.sv
rtl/core/msp_divsqrt.sv
rtl/core/mass_spring_particle_step.sv
sim/particle_step_checker.sv
sim/tb_mass_spring_particle_step.sv
